// ----- design/dprh_pkg.sv -----
`default_nettype none

package dprh_pkg;

    // Field widths of the item and result words.
    localparam int TEMP_W = 12;
    localparam int RH_W   = 16;

    // Vapour pressure table geometry.
    localparam int TABLE_ENTRIES      = 41;
    localparam int PRESSURE_FRAC_BITS = 22;
    localparam int SEG_IDX_W          = 6;
    localparam int SEG_OFF_W          = 8;

    // Integer bits of a table entry (the largest entry is 1013.25 hPa).
    localparam int ENTRY_INT_BITS = 10;

    // Temperature bounds and offset, in 1/16 degree.
    localparam logic signed [TEMP_W-1:0] TEMP_LOW    = -12'sd1600;
    localparam logic signed [TEMP_W-1:0] TEMP_HIGH   = 12'sd1680;
    localparam logic [TEMP_W:0]          TEMP_OFFSET = 13'd1600;

    // Highest segment index; values above it extrapolate the last segment.
    localparam logic [SEG_IDX_W-1:0] LAST_SEG = SEG_IDX_W'(TABLE_ENTRIES - 2);

    // Input word.
    typedef struct packed {
        logic signed [TEMP_W-1:0] air_temp;
        logic signed [TEMP_W-1:0] dew_point;
        logic                     air_missing;
        logic                     dew_missing;
    } t_item;

    // Result word.
    typedef struct packed {
        logic [RH_W-1:0] rel_humidity;
        logic            invalid;
        logic            saturated;
    } t_result;

    // Control that travels down the pipeline with each word.
    typedef struct packed {
        logic valid;
        logic bad;
    } t_ctl;

    // Saturation vapour pressure in micro-hPa, one entry every 5 degrees from -100.
    function automatic logic [31:0] svp_micro(input logic [SEG_IDX_W-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            6'd0:    v = 32'd34;
            6'd1:    v = 32'd89;
            6'd2:    v = 32'd220;
            6'd3:    v = 32'd517;
            6'd4:    v = 32'd1155;
            6'd5:    v = 32'd2472;
            6'd6:    v = 32'd5080;
            6'd7:    v = 32'd10050;
            6'd8:    v = 32'd19210;
            6'd9:    v = 32'd35530;
            6'd10:   v = 32'd63560;
            6'd11:   v = 32'd111100;
            6'd12:   v = 32'd189100;
            6'd13:   v = 32'd313900;
            6'd14:   v = 32'd508800;
            6'd15:   v = 32'd807000;
            6'd16:   v = 32'd1254000;
            6'd17:   v = 32'd1911800;
            6'd18:   v = 32'd2862700;
            6'd19:   v = 32'd4214800;
            6'd20:   v = 32'd6107800;
            6'd21:   v = 32'd8719200;
            6'd22:   v = 32'd12272000;
            6'd23:   v = 32'd17044000;
            6'd24:   v = 32'd23373000;
            6'd25:   v = 32'd31671000;
            6'd26:   v = 32'd42430000;
            6'd27:   v = 32'd56236000;
            6'd28:   v = 32'd73777000;
            6'd29:   v = 32'd95855000;
            6'd30:   v = 32'd123400000;
            6'd31:   v = 32'd157460000;
            6'd32:   v = 32'd199260000;
            6'd33:   v = 32'd250160000;
            6'd34:   v = 32'd311690000;
            6'd35:   v = 32'd385560000;
            6'd36:   v = 32'd473670000;
            6'd37:   v = 32'd578090000;
            6'd38:   v = 32'd701130000;
            6'd39:   v = 32'd845280000;
            6'd40:   v = 32'd1013250000;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- design/dprh_interp.sv -----
`default_nettype none

// Three-stage table interpolator: temperature to vapour pressure scaled by 80.
module dprh_interp #(
    parameter int FRAC = dprh_pkg::PRESSURE_FRAC_BITS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire dprh_pkg::t_ctl                        i_ctl,
    input  wire logic signed [dprh_pkg::TEMP_W-1:0]    i_temp,
    output dprh_pkg::t_ctl                             o_ctl,
    output logic [FRAC+dprh_pkg::ENTRY_INT_BITS+dprh_pkg::SEG_OFF_W-1:0] o_press
);

    localparam int E_W = FRAC + dprh_pkg::ENTRY_INT_BITS;
    localparam int P_W = E_W + dprh_pkg::SEG_OFF_W;

    // Stage A: offset temperature, segment index and offset within it.
    logic [dprh_pkg::TEMP_W:0]             n_u;
    logic                                  n_in_range;
    logic [17:0]                           n_prod;
    logic [7:0]                            n_seg_raw;
    logic [dprh_pkg::SEG_IDX_W-1:0]        n_seg;
    logic [dprh_pkg::TEMP_W-1:0]           n_seg80;
    logic [dprh_pkg::TEMP_W-1:0]           n_off_full;

    dprh_pkg::t_ctl                        r_a_ctl;
    logic [dprh_pkg::SEG_IDX_W-1:0]        r_a_seg;
    logic [dprh_pkg::SEG_OFF_W-1:0]        r_a_off;

    assign n_u        = {i_temp[dprh_pkg::TEMP_W-1], i_temp} + dprh_pkg::TEMP_OFFSET;
    assign n_in_range = (i_temp > dprh_pkg::TEMP_LOW) && (i_temp < dprh_pkg::TEMP_HIGH);
    // Divide by 80 as a shift by four and a reciprocal multiply for the fifth.
    assign n_prod     = 18'(n_u[dprh_pkg::TEMP_W-1:4]) * 18'd205;
    assign n_seg_raw  = n_prod[17:10];
    assign n_seg      = (n_seg_raw > 8'(dprh_pkg::LAST_SEG)) ? dprh_pkg::LAST_SEG
                                                              : n_seg_raw[5:0];
    assign n_seg80    = {n_seg, 6'b0} + {2'b0, n_seg, 4'b0};
    assign n_off_full = n_u[dprh_pkg::TEMP_W-1:0] - n_seg80;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
        end else begin
            r_a_ctl.valid <= i_ctl.valid;
            r_a_ctl.bad   <= i_ctl.bad || !n_in_range;
        end
        r_a_seg <= n_seg;
        r_a_off <= n_off_full[dprh_pkg::SEG_OFF_W-1:0];
    end

    // Table entries, rounded to FRAC fraction bits.
    logic [E_W-1:0] w_rom [dprh_pkg::TABLE_ENTRIES];

    for (genvar g = 0; g < dprh_pkg::TABLE_ENTRIES; g++) begin : g_rom
        assign w_rom[g] = E_W'(((64'(dprh_pkg::svp_micro(6'(g))) << FRAC) + 64'd500000)
                               / 64'd1000000);
    end

    // Stage B: neighbouring entries and their difference.
    logic [dprh_pkg::SEG_IDX_W-1:0] n_seg_hi;
    dprh_pkg::t_ctl                 r_b_ctl;
    logic [E_W-1:0]                 r_b_lo;
    logic [E_W-1:0]                 r_b_diff;
    logic [dprh_pkg::SEG_OFF_W-1:0] r_b_off;

    assign n_seg_hi = r_a_seg + 6'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl <= '0;
        end else begin
            r_b_ctl <= r_a_ctl;
        end
        r_b_lo   <= w_rom[r_a_seg];
        r_b_diff <= w_rom[n_seg_hi] - w_rom[r_a_seg];
        r_b_off  <= r_a_off;
    end

    // Stage C: 80 * low entry plus slope times offset.
    logic [P_W-1:0] n_mul;
    logic [P_W-1:0] n_press;
    dprh_pkg::t_ctl r_c_ctl;
    logic [P_W-1:0] r_c_press;

    assign n_mul   = P_W'(r_b_diff) * P_W'(r_b_off);
    assign n_press = P_W'({r_b_lo, 6'b0}) + P_W'({r_b_lo, 4'b0}) + n_mul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_ctl <= '0;
        end else begin
            r_c_ctl <= r_b_ctl;
        end
        r_c_press <= n_press;
    end

    assign o_ctl   = r_c_ctl;
    assign o_press = r_c_press;

endmodule

`default_nettype wire

// ----- design/dprh_div.sv -----
`default_nettype none

// Pipelined restoring divider: one saturation check stage, then one quotient bit a stage.
module dprh_div #(
    parameter int NUM_W = 51,
    parameter int DEN_W = 40,
    parameter int Q_W   = dprh_pkg::RH_W
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire dprh_pkg::t_ctl   i_ctl,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output dprh_pkg::t_ctl        o_ctl,
    output logic                  o_sat,
    output logic [Q_W-1:0]        o_quo
);

    localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    dprh_pkg::t_ctl   r_ctl [Q_W+1];
    logic             r_sat [Q_W+1];
    logic [CW-1:0]    r_rem [Q_W+1];
    logic [DEN_W-1:0] r_den [Q_W+1];
    logic [Q_W-1:0]   r_quo [Q_W+1];

    // Check stage: the quotient needs more than Q_W bits when num >= den * 2^Q_W.
    logic n_sat;
    assign n_sat = CW'(i_num) >= (CW'(i_den) << Q_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else begin
            r_ctl[0] <= i_ctl;
        end
        r_sat[0] <= n_sat;
        r_rem[0] <= CW'(i_num);
        r_den[0] <= i_den;
        r_quo[0] <= '0;
    end

    // Quotient stages, most significant bit first.
    for (genvar g = 1; g <= Q_W; g++) begin : g_step
        logic [CW-1:0] w_shift;
        logic          w_ge;
        logic [CW-1:0] n_rem;

        assign w_shift = CW'(r_den[g-1]) << (Q_W - g);
        assign w_ge    = r_rem[g-1] >= w_shift;
        assign n_rem   = w_ge ? (r_rem[g-1] - w_shift) : r_rem[g-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[g] <= '0;
            end else begin
                r_ctl[g] <= r_ctl[g-1];
            end
            r_sat[g] <= r_sat[g-1];
            r_rem[g] <= n_rem;
            r_den[g] <= r_den[g-1];
            r_quo[g] <= {r_quo[g-1][Q_W-2:0], w_ge};
        end
    end

    assign o_ctl = r_ctl[Q_W];
    assign o_sat = r_sat[Q_W];
    assign o_quo = r_quo[Q_W];

    // An unsaturated division must leave a remainder below the divisor.
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[Q_W].valid && !r_ctl[Q_W].bad && !r_sat[Q_W] && (r_den[Q_W] != '0)
        |-> r_rem[Q_W] < CW'(r_den[Q_W]))
        else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

// ----- design/dew_point_to_relative_humidity.sv -----
`default_nettype none

// Relative humidity from air temperature and dew point. A word is taken on
// every clock edge at which start is high and busy is low; busy is high only
// while reset is asserted, so one word per cycle is sustained. Each result
// appears on o_result for exactly one cycle, flagged by o_strobe, once its
// word has passed three stages of table interpolation, one stage forming
// the dividend, one saturation check, sixteen divider stages (one quotient
// bit each) and the output register. The receiver cannot stall the
// block and must take every result in the cycle it is shown. Words with a
// missing or out-of-range temperature come out with invalid set and zero
// humidity; quotients above 65535 come out as 65535 with saturated set.
module dew_point_to_relative_humidity #(
    parameter int PRESSURE_FRAC_BITS = dprh_pkg::PRESSURE_FRAC_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire dprh_pkg::t_item   i_item,
    output logic                   o_strobe,
    output dprh_pkg::t_result      o_result
);

    localparam int P_W   = PRESSURE_FRAC_BITS + dprh_pkg::ENTRY_INT_BITS + dprh_pkg::SEG_OFF_W;
    localparam int NUM_W = P_W + 11;

    logic           w_accept;
    dprh_pkg::t_ctl w_air_in;
    dprh_pkg::t_ctl w_dew_in;

    assign busy     = !i_rst_n;
    assign w_accept = start && !busy;

    assign w_air_in = '{valid: w_accept, bad: i_item.air_missing};
    assign w_dew_in = '{valid: w_accept, bad: i_item.dew_missing};

    // Pressure interpolation for both temperatures.
    dprh_pkg::t_ctl w_air_ctl;
    dprh_pkg::t_ctl w_dew_ctl;
    logic [P_W-1:0] w_air_press;
    logic [P_W-1:0] w_dew_press;

    dprh_interp #(.FRAC(PRESSURE_FRAC_BITS)) u_air (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_air_in),
        .i_temp  (i_item.air_temp),
        .o_ctl   (w_air_ctl),
        .o_press (w_air_press)
    );

    dprh_interp #(.FRAC(PRESSURE_FRAC_BITS)) u_dew (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_dew_in),
        .i_temp  (i_item.dew_point),
        .o_ctl   (w_dew_ctl),
        .o_press (w_dew_press)
    );

    // Dividend 1600 * dew pressure plus half the air pressure for rounding.
    logic [NUM_W-1:0] n_num;
    logic [P_W-1:0]   n_den;
    dprh_pkg::t_ctl   r_d_ctl;
    logic [NUM_W-1:0] r_d_num;
    logic [P_W-1:0]   r_d_den;

    assign n_num = NUM_W'({w_dew_press, 10'b0}) + NUM_W'({w_dew_press, 9'b0})
                 + NUM_W'({w_dew_press, 6'b0}) + NUM_W'(w_air_press >> 1);
    assign n_den = (w_air_press == '0) ? P_W'(1) : w_air_press;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_ctl <= '0;
        end else begin
            r_d_ctl.valid <= w_air_ctl.valid;
            r_d_ctl.bad   <= w_air_ctl.bad || w_dew_ctl.bad;
        end
        r_d_num <= n_num;
        r_d_den <= n_den;
    end

    // Division.
    dprh_pkg::t_ctl            w_q_ctl;
    logic                      w_q_sat;
    logic [dprh_pkg::RH_W-1:0] w_q_quo;

    dprh_div #(
        .NUM_W (NUM_W),
        .DEN_W (P_W),
        .Q_W   (dprh_pkg::RH_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_d_ctl),
        .i_num   (r_d_num),
        .i_den   (r_d_den),
        .o_ctl   (w_q_ctl),
        .o_sat   (w_q_sat),
        .o_quo   (w_q_quo)
    );

    // Output word: invalid words are forced to zero, large quotients clipped.
    dprh_pkg::t_result n_result;
    logic              r_strobe;
    dprh_pkg::t_result r_result;

    always_comb begin
        n_result.invalid = w_q_ctl.bad;
        priority if (w_q_ctl.bad) begin
            n_result.rel_humidity = '0;
            n_result.saturated    = 1'b0;
        end else if (w_q_sat) begin
            n_result.rel_humidity = '1;
            n_result.saturated    = 1'b1;
        end else begin
            n_result.rel_humidity = w_q_quo;
            n_result.saturated    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_q_ctl.valid;
        end
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // An invalid word carries no humidity and is never marked clipped.
    a_invalid_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.invalid
        |-> (o_result.rel_humidity == '0) && !o_result.saturated)
        else $error("invalid word with non-zero payload");

    // A clipped word holds the top of the range.
    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.saturated |-> o_result.rel_humidity == '1)
        else $error("saturated word not at maximum");

    // Reset empties the pipeline before the next cycle.
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("strobe after reset");

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    // Timing of the run.
    localparam int RESET_CYCLES = 12;
    localparam int PIPE_LATENCY = 22;
    localparam int DRAIN_CYCLES = 3 * PIPE_LATENCY;
    localparam int STALL_LIMIT  = 1000;
    localparam int RANDOM_WORDS = 1330;
    localparam int MAX_GAP      = 6;

    // Geometry of the vapour pressure curve, in 1/16 degree per segment.
    localparam int SEG_WIDTH = 80;
    localparam int RH_SCALE  = 1600;
    localparam int RH_MAX    = 65535;
    localparam longint unsigned MICRO = 64'd1000000;

    // One row of the directed stimulus.
    typedef struct {
        dprh_pkg::t_item   w;
        bit                known;
        dprh_pkg::t_result res;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    dprh_pkg::t_item   i_item;
    logic              o_strobe;
    dprh_pkg::t_result o_result;

    // Tag that travels with the word on the bus: a hand-typed answer, if any.
    bit                word_known;
    dprh_pkg::t_result word_answer;

    // Saturation vapour pressure over water, micro-hPa, every 5 degrees from -100.
    longint unsigned vap_micro_hpa [dprh_pkg::TABLE_ENTRIES] = '{
        34, 89, 220, 517, 1155, 2472,
        5080, 10050, 19210, 35530, 63560, 111100,
        189100, 313900, 508800, 807000, 1254000, 1911800,
        2862700, 4214800, 6107800, 8719200, 12272000, 17044000,
        23373000, 31671000, 42430000, 56236000, 73777000, 95855000,
        123400000, 157460000, 199260000, 250160000, 311690000, 385560000,
        473670000, 578090000, 701130000, 845280000, 1013250000
    };

    dprh_pkg::t_result humidity_due [$];
    t_row              directed [$];
    int                words_taken;
    int                results_seen;
    int                invalid_seen;
    int                clipped_seen;
    int                mismatches;
    int                quiet_cycles;
    bit                gaps_on;

    dew_point_to_relative_humidity uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Table entry in fixed point, rounded half up.
    function automatic longint unsigned vap_entry(input int idx);
        return ((vap_micro_hpa[idx] << dprh_pkg::PRESSURE_FRAC_BITS) + MICRO / 2) / MICRO;
    endfunction

    // Interpolated pressure times the segment width; the top segment is
    // extended upwards for temperatures from 100 degrees on.
    function automatic longint unsigned vap_pressure_x80(input int temp);
        int              pos;
        int              seg;
        longint unsigned lo;
        longint unsigned hi;
        pos = temp + int'(dprh_pkg::TEMP_OFFSET);
        seg = pos / SEG_WIDTH;
        if (seg > dprh_pkg::TABLE_ENTRIES - 2) begin
            seg = dprh_pkg::TABLE_ENTRIES - 2;
        end
        lo = vap_entry(seg);
        hi = vap_entry(seg + 1);
        return lo * SEG_WIDTH + (hi - lo) * longint'(pos - SEG_WIDTH * seg);
    endfunction

    // Expected result word for one input word.
    function automatic dprh_pkg::t_result humidity_of(input dprh_pkg::t_item w);
        dprh_pkg::t_result r;
        int                t_air;
        int                t_dew;
        longint unsigned   p_air;
        longint unsigned   p_dew;
        longint unsigned   rh;
        t_air = w.air_temp;
        t_dew = w.dew_point;
        r = '0;
        if (w.air_missing || w.dew_missing
                || t_air <= dprh_pkg::TEMP_LOW || t_air >= dprh_pkg::TEMP_HIGH
                || t_dew <= dprh_pkg::TEMP_LOW || t_dew >= dprh_pkg::TEMP_HIGH) begin
            r.invalid = 1'b1;
            return r;
        end
        p_air = vap_pressure_x80(t_air);
        p_dew = vap_pressure_x80(t_dew);
        if (p_air == 0) begin
            p_air = 1;
        end
        rh = (p_dew * RH_SCALE + p_air / 2) / p_air;
        if (rh > RH_MAX) begin
            r.rel_humidity = dprh_pkg::RH_W'(RH_MAX);
            r.saturated    = 1'b1;
        end else begin
            r.rel_humidity = dprh_pkg::RH_W'(rh);
        end
        return r;
    endfunction

    function automatic t_row make_row(input int air, input int dew, input bit air_gone,
                                      input bit dew_gone, input bit known, input int rh,
                                      input bit bad, input bit clip);
        t_row row;
        row.w.air_temp        = dprh_pkg::TEMP_W'(air);
        row.w.dew_point       = dprh_pkg::TEMP_W'(dew);
        row.w.air_missing     = air_gone;
        row.w.dew_missing     = dew_gone;
        row.known             = known;
        row.res.rel_humidity  = dprh_pkg::RH_W'(rh);
        row.res.invalid       = bad;
        row.res.saturated     = clip;
        return row;
    endfunction

    // Random word: mostly sound readings, some near the top of the table,
    // some with missing flags and some with any bit pattern at all.
    function automatic dprh_pkg::t_item gen_word();
        dprh_pkg::t_item w;
        int              kind;
        int              air;
        kind = $urandom_range(0, 99);
        w = '0;
        air = int'($urandom_range(0, 3278)) - 1599;
        w.air_temp = dprh_pkg::TEMP_W'(air);
        if (kind < 60) begin
            w.dew_point = dprh_pkg::TEMP_W'(int'($urandom_range(0, 3278)) - 1599);
        end else if (kind < 70) begin
            w.dew_point = dprh_pkg::TEMP_W'(air - int'($urandom_range(0, 200)));
        end else if (kind < 80) begin
            w.air_temp  = dprh_pkg::TEMP_W'(int'($urandom_range(1500, 1679)));
            w.dew_point = dprh_pkg::TEMP_W'(int'($urandom_range(0, 3278)) - 1599);
        end else if (kind < 90) begin
            w.dew_point   = dprh_pkg::TEMP_W'(int'($urandom_range(0, 3278)) - 1599);
            w.air_missing = 1'($urandom_range(0, 1));
            w.dew_missing = 1'($urandom_range(0, 1));
        end else begin
            w = dprh_pkg::t_item'($urandom);
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Offer one word after an optional random gap, and hold it until taken.
    task automatic send_word(input dprh_pkg::t_item w, input bit known,
                             input dprh_pkg::t_result answer);
        int gap;
        int target;
        gap = 0;
        if (gaps_on && $urandom_range(0, 99) < 7) begin
            gap = $urandom_range(1, MAX_GAP);
        end
        repeat (gap) begin
            start  = 1'b0;
            i_item = dprh_pkg::t_item'($urandom);
            @(negedge i_clk);
        end
        start       = 1'b1;
        i_item      = w;
        word_known  = known;
        word_answer = answer;
        target      = words_taken + 1;
        do @(negedge i_clk); while (words_taken < target);
    endtask

    // Take words and results at the rising edge; watch for a stalled run.
    always @(posedge i_clk) begin
        dprh_pkg::t_result want;
        bit                moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_strobe) begin
                moved = 1'b1;
                results_seen++;
                if (humidity_due.size() == 0) begin
                    report_mismatch("unexpected result word", 1, 0);
                end else begin
                    want = humidity_due.pop_front();
                    if (o_result.rel_humidity !== want.rel_humidity) begin
                        report_mismatch("rel_humidity", o_result.rel_humidity,
                                        want.rel_humidity);
                    end
                    if (o_result.invalid !== want.invalid) begin
                        report_mismatch("invalid", o_result.invalid, want.invalid);
                    end
                    if (o_result.saturated !== want.saturated) begin
                        report_mismatch("saturated", o_result.saturated, want.saturated);
                    end
                    invalid_seen += want.invalid;
                    clipped_seen += want.saturated;
                end
            end
            if (start && !busy) begin
                moved = 1'b1;
                words_taken++;
                humidity_due.push_back(word_known ? word_answer : humidity_of(i_item));
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("FAIL dew_point_to_relative_humidity");
                $finish;
            end
        end
    end

    initial begin
        dprh_pkg::t_result blank;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_item       = '0;
        word_known   = 1'b0;
        word_answer  = '0;
        words_taken  = 0;
        results_seen = 0;
        invalid_seen = 0;
        clipped_seen = 0;
        mismatches   = 0;
        quiet_cycles = 0;
        gaps_on      = 1'b1;
        blank        = '0;

        // Directed words: equal temperatures give exactly 100 percent, any
        // missing flag or out-of-range temperature gives the invalid word,
        // and the coldest air under the hottest dew point clips.
        directed.push_back(make_row(0, 0, 0, 0, 1, 1600, 0, 0));
        directed.push_back(make_row(0, 0, 1, 0, 1, 0, 1, 0));
        directed.push_back(make_row(0, 0, 0, 1, 1, 0, 1, 0));
        directed.push_back(make_row(0, 0, 1, 1, 1, 0, 1, 0));
        directed.push_back(make_row(-1600, 0, 0, 0, 1, 0, 1, 0));
        directed.push_back(make_row(1680, 0, 0, 0, 1, 0, 1, 0));
        directed.push_back(make_row(0, -1600, 0, 0, 1, 0, 1, 0));
        directed.push_back(make_row(0, 1680, 0, 0, 1, 0, 1, 0));
        directed.push_back(make_row(-2048, 0, 0, 0, 1, 0, 1, 0));
        directed.push_back(make_row(2047, 0, 0, 0, 1, 0, 1, 0));
        directed.push_back(make_row(0, -2048, 0, 0, 1, 0, 1, 0));
        directed.push_back(make_row(0, 2047, 0, 0, 1, 0, 1, 0));
        directed.push_back(make_row(2047, -2048, 1, 1, 1, 0, 1, 0));
        directed.push_back(make_row(-1599, -1599, 0, 0, 1, 1600, 0, 0));
        directed.push_back(make_row(1679, 1679, 0, 0, 1, 1600, 0, 0));
        directed.push_back(make_row(1600, 1600, 0, 0, 1, 1600, 0, 0));
        directed.push_back(make_row(-1599, 1679, 0, 0, 1, 65535, 0, 1));
        // The rest are left to the predictor: extrapolation above 100 degrees,
        // segment edges, dew above air without clipping, and small quotients.
        directed.push_back(make_row(1679, -1599, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(1600, 1599, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(1679, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(320, 240, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(400, 79, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(0, -80, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(200, 300, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(-800, -1000, 0, 0, 0, 0, 0, 0));

        // Synchronous reset, released on a falling edge.
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[k]) begin
            send_word(directed[k].w, directed[k].known, directed[k].res);
        end

        // Random words, with a long run of back-to-back words in the middle.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            gaps_on = !(n >= 400 && n < 700);
            send_word(gen_word(), 1'b0, blank);
        end
        start  = 1'b0;
        i_item = '0;

        // Wait for every result, then watch a while for stray strobes.
        while (humidity_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d words, checked %0d results (%0d invalid, %0d clipped).",
                 words_taken, results_seen, invalid_seen, clipped_seen);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0 && humidity_due.size() == 0) begin
            $display("PASS dew_point_to_relative_humidity");
        end else begin
            $display("FAIL dew_point_to_relative_humidity");
        end
        $finish;
    end

endmodule
